// ----- hw/rtl/imu_tilt_compensation_macros.svh -----
// ----------------------------------------------------------------------------
// IMU tilt compensation assertion macros
// Shared concurrent assertion forms. The asserting module must have clk_i and
// rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef IMU_TILT_COMPENSATION_MACROS_SVH
`define IMU_TILT_COMPENSATION_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define IMUTC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication.
`define IMUTC_ASSERT_IMPLY(name, pre, post, msg) \
  `IMUTC_ASSERT(name, (pre) |-> (post), msg)

`endif

// ----- hw/rtl/imutc_pkg.sv -----
// ----------------------------------------------------------------------------
// IMU tilt compensation package
// Angle constants, the pipeline control bundle and the sine table generator.
// ----------------------------------------------------------------------------
`default_nettype none

package imutc_pkg;

  localparam int unsigned SINE_TABLE_BITS_DFLT = 10;

  // Angles are Q.7 degrees.
  localparam int unsigned CIRCLE_Q7 = 46080;
  localparam int unsigned HALF_Q7   = 23040;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // Stage enables and valid flags handed to the trigonometry pipeline.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic v2;
    logic v3;
  } imutc_ctl_t;

  // Quarter-wave sine entry j in Q1.15, for a quarter circle of 2^qbits steps.
  // Evaluated at elaboration only: Taylor series in Q2.30 up to x^11.
  function automatic logic [15:0] sine_entry(input int unsigned j,
                                             input int unsigned qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    longint      sum;
    x    = (64'(j) * PI_HALF_Q30) >> qbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) << 30)) begin
      sum = longint'(1) << 30;
    end
    v = ((unsigned'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/imutc_trig.sv -----
// ----------------------------------------------------------------------------
// IMU tilt compensation sine and cosine pipeline
// Maps a Q9.7 degree angle to the nearest table step and looks up its sine
// and cosine in a quarter-wave ROM. Four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

`include "imu_tilt_compensation_macros.svh"

module imutc_trig import imutc_pkg::*; #(
  parameter int unsigned TABLE_BITS = SINE_TABLE_BITS_DFLT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire imutc_ctl_t         ctl_i,
  input  wire logic        [15:0] angle_i,
  output logic signed      [15:0] sin_o,
  output logic signed      [15:0] cos_o
);

  localparam int unsigned N     = 1 << TABLE_BITS;
  localparam int unsigned Q     = 1 << (TABLE_BITS - 2);
  localparam int unsigned SUMW  = 16 + TABLE_BITS;
  localparam int unsigned TW    = TABLE_BITS + 6;
  localparam int unsigned RS    = TW + 6;
  localparam int unsigned MW    = TW + 1;
  localparam int unsigned PRW   = TW + MW;
  localparam int unsigned QW    = TW - 5;
  localparam int unsigned IW    = TABLE_BITS - 1;
  localparam logic [MW-1:0] RECIP = MW'((longint'(1) << RS) / 45);

  function automatic logic [(Q+1)*16-1:0] build_rom();
    logic [(Q+1)*16-1:0] r;
    r = '0;
    for (int j = 0; j <= int'(Q); j++) begin
      r[j*16 +: 16] = sine_entry(32'(j), 32'(TABLE_BITS - 2));
    end
    return r;
  endfunction

  localparam logic [(Q+1)*16-1:0] ROM_BITS = build_rom();

  // Stage 1: reduce modulo a full circle and scale to steps (times 1/1024).
  logic [15:0]     amod;
  logic [SUMW-1:0] scaled;
  logic [TW-1:0]   t_q;

  always_comb begin
    amod   = (angle_i >= 16'(CIRCLE_Q7)) ? angle_i - 16'(CIRCLE_Q7) : angle_i;
    scaled = {amod, {TABLE_BITS{1'b0}}} + SUMW'(HALF_Q7);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en1) begin
      t_q <= scaled[SUMW-1:10];
    end
  end

  // Stage 2: divide by 45 through a reciprocal.
  logic [PRW-1:0] prod_q;
  logic [TW-1:0]  t2_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en2) begin
      prod_q <= PRW'(t_q) * PRW'(RECIP);
      t2_q   <= t_q;
    end
  end

  // Stage 3: correct the estimate by one and fold steps into the quarter wave.
  logic [QW-1:0]         q_est;
  logic [TW-1:0]         rem;
  logic [QW-1:0]         q_fix;
  logic [TABLE_BITS-1:0] sin_step;
  logic [TABLE_BITS-1:0] cos_step;
  logic [IW-1:0]         sin_idx_d;
  logic [IW-1:0]         cos_idx_d;
  logic [IW-1:0]         sin_idx_q;
  logic [IW-1:0]         cos_idx_q;
  logic                  sin_neg_q;
  logic                  cos_neg_q;

  always_comb begin
    q_est    = prod_q[PRW-1:RS];
    rem      = t2_q - (TW'(q_est) * TW'(45));
    q_fix    = q_est + QW'(rem >= TW'(45));
    sin_step = q_fix[TABLE_BITS-1:0];
    cos_step = sin_step + TABLE_BITS'(Q);
    sin_idx_d = sin_step[TABLE_BITS-2] ?
                IW'(Q) - IW'(sin_step[TABLE_BITS-3:0]) : IW'(sin_step[TABLE_BITS-3:0]);
    cos_idx_d = cos_step[TABLE_BITS-2] ?
                IW'(Q) - IW'(cos_step[TABLE_BITS-3:0]) : IW'(cos_step[TABLE_BITS-3:0]);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en3) begin
      sin_idx_q <= sin_idx_d;
      cos_idx_q <= cos_idx_d;
      sin_neg_q <= sin_step[TABLE_BITS-1];
      cos_neg_q <= cos_step[TABLE_BITS-1];
    end
  end

  // Stage 4: registered ROM read.
  logic [15:0] sin_mag_q;
  logic [15:0] cos_mag_q;
  logic        sin_neg4_q;
  logic        cos_neg4_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en4) begin
      sin_mag_q  <= ROM_BITS[{sin_idx_q, 4'b0000} +: 16];
      cos_mag_q  <= ROM_BITS[{cos_idx_q, 4'b0000} +: 16];
      sin_neg4_q <= sin_neg_q;
      cos_neg4_q <= cos_neg_q;
    end
  end

  // Table entries never exceed 32767, so the magnitude is a valid positive.
  assign sin_o = sin_neg4_q ? 16'sd0 - $signed(sin_mag_q) : $signed(sin_mag_q);
  assign cos_o = cos_neg4_q ? 16'sd0 - $signed(cos_mag_q) : $signed(cos_mag_q);

  `IMUTC_ASSERT_IMPLY(a_recip_error, ctl_i.v2, rem < TW'(90), "reciprocal estimate off by more than one")
  `IMUTC_ASSERT_IMPLY(a_step_bound, ctl_i.v2, q_fix <= QW'(N), "angle step beyond a full circle")
  `IMUTC_ASSERT_IMPLY(a_rom_index, ctl_i.v3, (sin_idx_q <= IW'(Q)) && (cos_idx_q <= IW'(Q)), "quarter-wave index out of range")

endmodule

`default_nettype wire

// ----- hw/rtl/imu_tilt_compensation.sv -----
// IMU tilt compensation: one sample enters per clock unless stall_o is high;
// its result passes through the eight register stages of the pipeline (angle
// scaling, reciprocal divide, step folding, sine ROM read, two multiply levels,
// the sums, and rounding with saturation). Each stage holds its data only
// while the stage after it is full and stalled, so bubbles close up and stall_o
// rises only when all eight stages hold a transaction and stall_i is high.
// The sine ROM holds 2^(SINE_TABLE_BITS-2)+1 entries, one copy per lookup.
// ----------------------------------------------------------------------------
// IMU tilt compensation top level
// Wraps roll and pitch, rotates the scaled acceleration into the level frame
// and corrects the range reading by cos(roll)*cos(pitch).
// ----------------------------------------------------------------------------
`default_nettype none

`include "imu_tilt_compensation_macros.svh"

module imu_tilt_compensation import imutc_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DFLT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    stall_o,
  input  wire logic        [15:0] range_raw_i,
  input  wire logic        [15:0] roll_raw_i,
  input  wire logic        [15:0] pitch_raw_i,
  input  wire logic signed [15:0] acc_sim_x_i,
  input  wire logic signed [15:0] acc_sim_up_i,
  input  wire logic signed [15:0] acc_sim_z_i,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output logic signed      [15:0] roll_wrapped_o,
  output logic signed      [15:0] pitch_wrapped_o,
  output logic signed      [15:0] acc_level_x_o,
  output logic signed      [15:0] acc_level_y_o,
  output logic signed      [15:0] acc_level_z_o,
  output logic signed      [16:0] height_level_o
);

  localparam int unsigned NST = 8;
  localparam logic [55:0] ACC_BIAS = 56'd1 << 37;
  localparam logic [47:0] H_BIAS   = 48'd1 << 29;

  // Round half away from zero by 2^38, then saturate to 16 bits.
  function automatic logic signed [15:0] sat_acc(input logic signed [55:0] v);
    logic [55:0]        r;
    logic signed [17:0] q;
    r = v + ACC_BIAS - {55'd0, v[55]};
    q = $signed(r[55:38]);
    if (q > 18'sd32767) begin
      return 16'sh7fff;
    end else if (q < -18'sd32768) begin
      return 16'sh8000;
    end else begin
      return q[15:0];
    end
  endfunction

  // Round half away from zero by 2^30, then clamp to +/-65535.
  function automatic logic signed [16:0] sat_height(input logic signed [47:0] v);
    logic [47:0]        r;
    logic signed [17:0] q;
    r = v + H_BIAS - {47'd0, v[47]};
    q = $signed(r[47:30]);
    if (q > 18'sd65535) begin
      return 17'sd65535;
    end else if (q < -18'sd65535) begin
      return -17'sd65535;
    end else begin
      return q[16:0];
    end
  endfunction

  // Pipeline control: a stage may load when it is empty or the next one loads.
  logic [NST+1:1] en;
  logic [NST:1]   v_q;
  logic [NST:1]   v_d;
  imutc_ctl_t     trig_ctl;

  always_comb begin
    en[NST+1] = !stall_i;
    for (int k = NST; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = {v_q[NST-1:1], valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  assign stall_o = !en[1];
  assign valid_o = v_q[NST];

  assign trig_ctl = '{en1: en[1], en2: en[2], en3: en[3], en4: en[4],
                      v2: v_q[2], v3: v_q[3]};

  // Sine and cosine of roll (a) and pitch (b), valid at stage 4.
  logic signed [15:0] sa;
  logic signed [15:0] ca;
  logic signed [15:0] sb;
  logic signed [15:0] cb;

  imutc_trig #(
    .TABLE_BITS(SINE_TABLE_BITS)
  ) u_trig_roll (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (trig_ctl),
    .angle_i(roll_raw_i),
    .sin_o  (sa),
    .cos_o  (ca)
  );

  imutc_trig #(
    .TABLE_BITS(SINE_TABLE_BITS)
  ) u_trig_pitch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (trig_ctl),
    .angle_i(pitch_raw_i),
    .sin_o  (sb),
    .cos_o  (cb)
  );

  // Stage 1: angle wrap and scaling to cm/s^2 (lateral and vertical swapped).
  logic signed [15:0] roll_w_d;
  logic signed [15:0] pitch_w_d;
  logic signed [15:0] roll_w_q  [1:NST-1];
  logic signed [15:0] pitch_w_q [1:NST-1];
  logic signed [22:0] ax_q      [1:4];
  logic signed [22:0] ay_q      [1:5];
  logic signed [22:0] az_q      [1:5];
  logic        [15:0] range_q   [1:5];

  always_comb begin
    roll_w_d  = (roll_raw_i < 16'(HALF_Q7)) ? $signed(roll_raw_i) :
                $signed(roll_raw_i - 16'(CIRCLE_Q7));
    pitch_w_d = (pitch_raw_i < 16'(HALF_Q7)) ? $signed(pitch_raw_i) :
                $signed(pitch_raw_i - 16'(CIRCLE_Q7));
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      roll_w_q[1]  <= roll_w_d;
      pitch_w_q[1] <= pitch_w_d;
      ax_q[1]      <= 23'(acc_sim_x_i) * 23'sd100;
      ay_q[1]      <= 23'(acc_sim_z_i) * 23'sd100;
      az_q[1]      <= 23'(acc_sim_up_i) * 23'sd100;
      range_q[1]   <= range_raw_i;
    end
    for (int k = 2; k <= int'(NST) - 1; k++) begin
      if (en[k]) begin
        roll_w_q[k]  <= roll_w_q[k-1];
        pitch_w_q[k] <= pitch_w_q[k-1];
      end
    end
    for (int k = 2; k <= 4; k++) begin
      if (en[k]) begin
        ax_q[k] <= ax_q[k-1];
      end
    end
    for (int k = 2; k <= 5; k++) begin
      if (en[k]) begin
        ay_q[k]    <= ay_q[k-1];
        az_q[k]    <= az_q[k-1];
        range_q[k] <= range_q[k-1];
      end
    end
  end

  // Stage 5: trig products and first acceleration products.
  logic signed [30:0] p_casb_q;
  logic signed [30:0] p_sasb_q;
  logic signed [30:0] p_cacb_q;
  logic signed [30:0] p_cbsa_q;
  logic signed [38:0] m_axcb_q;
  logic signed [38:0] m_ayca_q;
  logic signed [38:0] m_azsa_q;
  logic signed [38:0] m_axsb_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      p_casb_q <= ca * sb;
      p_sasb_q <= sa * sb;
      p_cacb_q <= ca * cb;
      p_cbsa_q <= cb * sa;
      m_axcb_q <= ax_q[4] * cb;
      m_ayca_q <= ay_q[4] * ca;
      m_azsa_q <= az_q[4] * sa;
      m_axsb_q <= ax_q[4] * sb;
    end
  end

  // Stage 6: second-level products, all terms in Q38 (the Q23 ones shifted later).
  logic signed [53:0] t_x2_q;
  logic signed [53:0] t_x3_q;
  logic signed [53:0] t_z1_q;
  logic signed [53:0] t_z3_q;
  logic signed [38:0] t_x1_q;
  logic signed [38:0] t_z2_q;
  logic signed [39:0] t_y_q;
  logic signed [47:0] h_p_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      t_x1_q <= m_axcb_q;
      t_x2_q <= az_q[5] * p_casb_q;
      t_x3_q <= ay_q[5] * p_sasb_q;
      t_y_q  <= 40'(m_ayca_q) - 40'(m_azsa_q);
      t_z1_q <= az_q[5] * p_cacb_q;
      t_z2_q <= m_axsb_q;
      t_z3_q <= ay_q[5] * p_cbsa_q;
      h_p_q  <= $signed({1'b0, range_q[5]}) * p_cacb_q;
    end
  end

  // Stage 7: exact sums.
  logic signed [55:0] vx_q;
  logic signed [55:0] vy_q;
  logic signed [55:0] vz_q;
  logic signed [47:0] h_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      vx_q <= 56'($signed({t_x1_q, 15'd0})) + 56'(t_x2_q) + 56'(t_x3_q);
      vy_q <= 56'($signed({t_y_q, 15'd0}));
      vz_q <= 56'(t_z1_q) - 56'($signed({t_z2_q, 15'd0})) + 56'(t_z3_q);
      h_q  <= h_p_q;
    end
  end

  // Stage 8: rounding and saturation into the output register.
  logic signed [15:0] roll_out_q;
  logic signed [15:0] pitch_out_q;
  logic signed [15:0] acc_x_q;
  logic signed [15:0] acc_y_q;
  logic signed [15:0] acc_z_q;
  logic signed [16:0] height_q;

  always_ff @(posedge clk_i) begin
    if (en[NST]) begin
      roll_out_q  <= roll_w_q[NST-1];
      pitch_out_q <= pitch_w_q[NST-1];
      acc_x_q     <= sat_acc(vx_q);
      acc_y_q     <= sat_acc(vy_q);
      acc_z_q     <= sat_acc(vz_q);
      height_q    <= sat_height(h_q);
    end
  end

  assign roll_wrapped_o  = roll_out_q;
  assign pitch_wrapped_o = pitch_out_q;
  assign acc_level_x_o   = acc_x_q;
  assign acc_level_y_o   = acc_y_q;
  assign acc_level_z_o   = acc_z_q;
  assign height_level_o  = height_q;

  `IMUTC_ASSERT_IMPLY(a_stall_only_when_full, stall_o, &v_q, "input stalled while a pipeline stage is empty")
  `IMUTC_ASSERT_IMPLY(a_roll_range, valid_o, (roll_wrapped_o >= -16'sd23040) && (roll_wrapped_o <= 16'sd23039), "wrapped roll out of range")
  `IMUTC_ASSERT_IMPLY(a_pitch_range, valid_o, (pitch_wrapped_o >= -16'sd23040) && (pitch_wrapped_o <= 16'sd23039), "wrapped pitch out of range")

endmodule

`default_nettype wire
